@@ rtl/core/fclr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fclr_pkg
// Shared constants and codes for the fully connected layer with relu.
// ----------------------------------------------------------------------------
package fclr_pkg;

	// default sizes of the activation store and the neuron range
	localparam int IN_MAX_DEF  = 4096;
	localparam int OUT_MAX_DEF = 1024;

	// register reset values
	localparam int IN_COUNT_RST  = 256 * 9;
	localparam int OUT_COUNT_RST = 1024;

	// field widths
	localparam int VALUE_W     = 16;
	localparam int OUT_INDEX_W = 10;
	localparam int IN_COUNT_W  = 13;
	localparam int OUT_COUNT_W = 11;
	localparam int PROD_W      = 32;
	localparam int SUM_W       = 48;

	// configuration port
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 13;

	localparam logic [CFG_INDEX_W-1:0] CFG_RELU_ENABLE = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_IN_COUNT    = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_OUT_COUNT   = 2'd2;

	// input item kinds
	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_WEIGHT = 1'b1;

endpackage

@@ rtl/core/fully_connected_layer_relu_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fully_connected_layer_relu_top
// datapath: a row's last weight transaction passes the store read and stage 1,
//   the stage 2 product and the stage 3 accumulator into the output register
// throughput: one input transaction per cycle; the pipeline stalls only while
//   a finished neuron result waits on the output and another is ready behind it
// reset: arst_n clears counters, the running sum, valid bits and registers to
//   their defaults; the activation store is not cleared
// ----------------------------------------------------------------------------
module fully_connected_layer_relu_top #(
	parameter int IN_MAX  = fclr_pkg::IN_MAX_DEF,
	parameter int OUT_MAX = fclr_pkg::OUT_MAX_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration write channel
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [fclr_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [fclr_pkg::CFG_DATA_W-1:0]      cfg_data,
	// input item channel
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 op,
	input  logic signed [fclr_pkg::VALUE_W-1:0]  value,
	// result channel
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [fclr_pkg::VALUE_W-1:0]  out_value,
	output logic [fclr_pkg::OUT_INDEX_W-1:0]     out_index,
	output logic                                 last
);
	import fclr_pkg::*;

	// column and row position widths; counts are held in effective form
	localparam int COL_W  = $clog2(IN_MAX);
	localparam int IN_CW  = $clog2(IN_MAX + 1);
	localparam int ROW_W  = (OUT_MAX > 1) ? $clog2(OUT_MAX) : 1;
	localparam int OUT_CW = $clog2(OUT_MAX + 1);
	// wide enough to compare a raw register write against the clamp limit
	localparam int INC_W  = (IN_CW > IN_COUNT_W) ? IN_CW : IN_COUNT_W;
	localparam int OUTC_W = (OUT_CW > OUT_COUNT_W) ? OUT_CW : OUT_COUNT_W;
	localparam int IN_RST_EFF  = (IN_COUNT_RST > IN_MAX) ? IN_MAX : IN_COUNT_RST;
	localparam int OUT_RST_EFF = (OUT_COUNT_RST > OUT_MAX) ? OUT_MAX : OUT_COUNT_RST;

	// ------------------------------------------------------------------
	// configuration registers, clamped to their legal range on write
	// ------------------------------------------------------------------
	logic              relu_q;
	logic [IN_CW-1:0]  in_eff_q;
	logic [OUT_CW-1:0] out_eff_q;
	logic [INC_W-1:0]  in_wr;
	logic [OUTC_W-1:0] out_wr;
	logic [IN_CW-1:0]  in_wr_eff;
	logic [OUT_CW-1:0] out_wr_eff;

	assign cfg_ready = 1'b1;

	always_comb begin
		in_wr  = INC_W'(cfg_data[IN_COUNT_W-1:0]);
		out_wr = OUTC_W'(cfg_data[OUT_COUNT_W-1:0]);
		// zero acts as one, anything past the store size acts as the size
		if (in_wr == '0) begin
			in_wr_eff = IN_CW'(1);
		end else if (in_wr > INC_W'(IN_MAX)) begin
			in_wr_eff = IN_CW'(IN_MAX);
		end else begin
			in_wr_eff = IN_CW'(in_wr);
		end
		if (out_wr == '0) begin
			out_wr_eff = OUT_CW'(1);
		end else if (out_wr > OUTC_W'(OUT_MAX)) begin
			out_wr_eff = OUT_CW'(OUT_MAX);
		end else begin
			out_wr_eff = OUT_CW'(out_wr);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relu_q    <= 1'b1;
			in_eff_q  <= IN_CW'(IN_RST_EFF);
			out_eff_q <= OUT_CW'(OUT_RST_EFF);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_RELU_ENABLE: relu_q    <= cfg_data[0];
				CFG_IN_COUNT:    in_eff_q  <= in_wr_eff;
				CFG_OUT_COUNT:   out_eff_q <= out_wr_eff;
				default: ;  // writes past the register list are dropped
			endcase
		end
	end

	// ------------------------------------------------------------------
	// flow control: the only stall is a finished neuron in stage 3 that
	// cannot move into an occupied output register
	// ------------------------------------------------------------------
	logic advance;
	logic accept;
	logic fin_valid_s3;
	logic out_valid_q;

	assign advance  = !(fin_valid_s3 && out_valid_q && !out_ready);
	assign in_ready = advance;
	assign accept   = in_valid && advance;

	// ------------------------------------------------------------------
	// position counters
	// ------------------------------------------------------------------
	logic [COL_W-1:0] load_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] ld_addr;
	logic [COL_W-1:0] ld_next;
	logic             row_end;
	logic             pass_end;

	always_comb begin
		// load position restarts if in_count shrank below it
		ld_addr  = (IN_CW'(load_q) >= in_eff_q) ? '0 : load_q;
		ld_next  = (IN_CW'(ld_addr) + IN_CW'(1) >= in_eff_q) ? '0 : COL_W'(ld_addr + 1'b1);
		row_end  = (IN_CW'(col_q) + IN_CW'(1) >= in_eff_q);
		pass_end = (OUT_CW'(row_q) + OUT_CW'(1) >= out_eff_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_q <= '0;
			col_q  <= '0;
			row_q  <= '0;
		end else if (accept) begin
			if (op == OP_LOAD) begin
				load_q <= ld_next;
			end else begin
				col_q <= row_end ? '0 : COL_W'(col_q + 1'b1);
				if (row_end) begin
					row_q <= pass_end ? '0 : ROW_W'(row_q + 1'b1);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// activation store: one write port for loads, one registered read
	// port addressed by the column position for weights
	// ------------------------------------------------------------------
	logic [VALUE_W-1:0] act_mem [IN_MAX];
	logic signed [VALUE_W-1:0] act_s1;

	always_ff @(posedge clk) begin
		if (accept && op == OP_LOAD) begin
			act_mem[ld_addr] <= value;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			act_s1 <= act_mem[col_q];
		end
	end

	// ------------------------------------------------------------------
	// stage 1: weight and row flags, aligned with the store read data
	// ------------------------------------------------------------------
	typedef struct packed {
		logic                   row_end;
		logic                   pass_end;
		logic [OUT_INDEX_W-1:0] index;
	} row_info_t;

	logic                      v_s1;
	logic signed [VALUE_W-1:0] w_s1;
	row_info_t                 info_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (advance) begin
			v_s1 <= accept && (op == OP_WEIGHT);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			w_s1             <= value;
			info_s1.row_end  <= row_end;
			info_s1.pass_end <= pass_end;
			info_s1.index    <= OUT_INDEX_W'(row_q);
		end
	end

	// ------------------------------------------------------------------
	// stage 2: q8.8 by q8.8 product, q16.16 in 32 bits
	// ------------------------------------------------------------------
	logic                     v_s2;
	logic signed [PROD_W-1:0] prod_s2;
	row_info_t                info_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (advance) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			prod_s2 <= PROD_W'(act_s1) * PROD_W'(w_s1);
			info_s2 <= info_s1;
		end
	end

	// ------------------------------------------------------------------
	// stage 3: 48-bit accumulate; a finished row is captured and the
	// running sum cleared
	// ------------------------------------------------------------------
	logic [SUM_W-1:0] sum_q;
	logic [SUM_W-1:0] sum_next;
	logic [SUM_W-1:0] fin_sum_s3;
	row_info_t        info_s3;

	assign sum_next = sum_q + SUM_W'(prod_s2);  // sign extends the product

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q        <= '0;
			fin_valid_s3 <= 1'b0;
		end else if (advance) begin
			fin_valid_s3 <= v_s2 && info_s2.row_end;
			if (v_s2) begin
				sum_q <= info_s2.row_end ? '0 : sum_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			fin_sum_s3 <= sum_next;
			info_s3    <= info_s2;
		end
	end

	// ------------------------------------------------------------------
	// stage 4: round half up to q8.8, saturate, relu, into the output
	// register
	// ------------------------------------------------------------------
	logic signed [SUM_W:0]       rnd;
	logic signed [SUM_W-8:0]     quo;
	logic signed [VALUE_W-1:0]   sat;
	logic signed [VALUE_W-1:0]   res;
	logic                        fits;
	logic                        load_out;

	always_comb begin
		rnd  = $signed({fin_sum_s3[SUM_W-1], fin_sum_s3}) + (SUM_W + 1)'(128);
		quo  = rnd[SUM_W:8];  // floor of the division by 256
		fits = (quo[SUM_W-8:VALUE_W-1] == '0) || (quo[SUM_W-8:VALUE_W-1] == '1);
		if (fits) begin
			sat = quo[VALUE_W-1:0];
		end else if (quo[SUM_W-8]) begin
			sat = {1'b1, {(VALUE_W-1){1'b0}}};
		end else begin
			sat = {1'b0, {(VALUE_W-1){1'b1}}};
		end
		res = (relu_q && sat[VALUE_W-1]) ? '0 : sat;
	end

	assign load_out = advance && fin_valid_s3;

	logic [OUT_INDEX_W-1:0] out_index_q;
	logic                   last_q;
	logic [VALUE_W-1:0]     out_value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_value_q <= res;
			out_index_q <= info_s3.index;
			last_q      <= info_s3.pass_end;
		end
	end

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign out_index = out_index_q;
	assign last      = last_q;

endmodule

@@ rtl/core/fclr_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fclr_checker
// Port-level checks for the fully connected layer, bound to the top level.
// ----------------------------------------------------------------------------
module fclr_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                cfg_valid,
	input logic                                cfg_ready,
	input logic [fclr_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input logic [fclr_pkg::CFG_DATA_W-1:0]     cfg_data,
	input logic                                in_ready,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic [fclr_pkg::VALUE_W-1:0]        out_value,
	input logic [fclr_pkg::OUT_INDEX_W-1:0]    out_index,
	input logic                                last
);
	import fclr_pkg::*;

	// relu setting as seen from configuration transactions
	logic relu_seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relu_seen_q <= 1'b1;
		end else if (cfg_valid && cfg_ready && cfg_index == CFG_RELU_ENABLE) begin
			relu_seen_q <= cfg_data[0];
		end
	end

	// a waiting result holds its contents
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_value)
			&& $stable(out_index) && $stable(last))
		else $error("result changed while stalled");

	// no result is shown on the edge after one seen in reset
	a_reset_idle: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("result valid during reset");

	// input is only held off by output backpressure
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output backpressure");

	// relu never lets a negative neuron through
	a_relu: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && relu_seen_q |-> !out_value[VALUE_W-1])
		else $error("negative result with relu enabled");

endmodule

bind fully_connected_layer_relu_top fclr_checker u_fclr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready),
	.cfg_index (cfg_index),
	.cfg_data  (cfg_data),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_value (out_value),
	.out_index (out_index),
	.last      (last)
);

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the fully connected layer with relu. It streams
// activation and weight transactions with random gaps and output stalls,
// computes every neuron result on its own, and checks the result port in
// order, field by field.
// ----------------------------------------------------------------------------
module tb_top;
	import fclr_pkg::*;

	localparam int IN_MAX  = IN_MAX_DEF;
	localparam int OUT_MAX = OUT_MAX_DEF;
	localparam int ADDR_W  = $clog2(IN_MAX);

	// register index that maps to no register
	localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

	// margin for the pipe to drain before touching registers
	localparam int SETTLE_CYCLES   = 8;
	localparam int HOLD_CYCLES     = 300;
	localparam int LIMIT_CYCLES    = 2000000;
	localparam int RANDOM_ITEMS    = 1600;
	localparam int MAX_SHOWN       = 10;

	typedef struct packed {
		logic [VALUE_W-1:0]     value;
		logic [OUT_INDEX_W-1:0] index;
		logic                   last;
	} neuron_t;

	// dut ports, every input known from time zero
	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [CFG_INDEX_W-1:0]          cfg_index = '0;
	logic [CFG_DATA_W-1:0]           cfg_data  = '0;
	logic                            in_valid  = 1'b0;
	logic                            in_ready;
	logic                            op        = OP_LOAD;
	logic signed [VALUE_W-1:0]       value     = '0;
	logic                            out_valid;
	logic                            out_ready = 1'b0;
	logic signed [VALUE_W-1:0]       out_value;
	logic [OUT_INDEX_W-1:0]          out_index;
	logic                            last;

	// bench copy of the layer state and registers, reset values
	logic [VALUE_W-1:0]              act_mem [IN_MAX];
	int unsigned                     load_pos    = 0;
	int unsigned                     col_pos     = 0;
	int unsigned                     row_pos     = 0;
	logic [SUM_W-1:0]                row_sum     = '0;
	logic                            relu_on     = 1'b1;
	logic [IN_COUNT_W-1:0]           in_count_q  = IN_COUNT_W'(IN_COUNT_RST);
	logic [OUT_COUNT_W-1:0]          out_count_q = OUT_COUNT_W'(OUT_COUNT_RST);

	// neuron results still owed by the dut, oldest first
	neuron_t                         pending_neurons [$];
	neuron_t                         owed;

	int unsigned                     items_sent  = 0;
	int                              bad_results = 0;
	int                              cycle_count = 0;

	// idle control for both sides
	bit                              tx_gaps_on = 1'b1;
	bit                              rx_gaps_on = 1'b1;
	int                              hold_req   = 0;
	int                              hold_seen  = 0;
	int                              rx_wait    = 0;

	fully_connected_layer_relu_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_value (out_value),
		.out_index (out_index),
		.last      (last)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("fully_connected_layer_relu_top: mismatch");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// layer predictor
	// ------------------------------------------------------------------------

	// out-of-range counts are clamped: zero acts as one, overflow as the max
	function automatic int unsigned row_length();
		if (in_count_q == 0)
			return 1;
		if (in_count_q > IN_MAX)
			return IN_MAX;
		return 32'(in_count_q);
	endfunction

	function automatic int unsigned pass_length();
		if (out_count_q == 0)
			return 1;
		if (out_count_q > OUT_MAX)
			return OUT_MAX;
		return 32'(out_count_q);
	endfunction

	// q16.16 sum to q8.8: round half up, saturate, then relu
	function automatic logic [VALUE_W-1:0] neuron_output(input logic [SUM_W-1:0] sum);
		logic signed [SUM_W:0]   rounded;
		logic signed [SUM_W-8:0] scaled;
		rounded = $signed({sum[SUM_W-1], sum}) + 128;
		scaled  = rounded[SUM_W:8];
		if (relu_on && scaled < 0)
			return '0;
		if (scaled > 32767)
			return 16'h7FFF;
		if (scaled < -32768)
			return 16'h8000;
		return scaled[VALUE_W-1:0];
	endfunction

	function automatic void apply_register(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
			CFG_RELU_ENABLE: relu_on     = data[0];
			CFG_IN_COUNT:    in_count_q  = data[IN_COUNT_W-1:0];
			CFG_OUT_COUNT:   out_count_q = data[OUT_COUNT_W-1:0];
			default: ;
		endcase
	endfunction

	// one accepted transaction; queues the neuron result when a row closes
	function automatic void predict_layer_item(input logic kind, input logic [VALUE_W-1:0] v);
		int unsigned              n_in;
		int unsigned              n_out;
		logic signed [PROD_W-1:0] prod;
		neuron_t                  done_row;
		n_in  = row_length();
		n_out = pass_length();
		if (kind == OP_LOAD) begin
			// load pointer restarts when the row length shrank below it
			if (load_pos >= n_in)
				load_pos = 0;
			act_mem[load_pos[ADDR_W-1:0]] = v;
			load_pos++;
			if (load_pos >= n_in)
				load_pos = 0;
			return;
		end
		prod    = $signed(act_mem[col_pos[ADDR_W-1:0]]) * $signed(v);
		row_sum = row_sum + {{(SUM_W-PROD_W){prod[PROD_W-1]}}, prod};
		col_pos++;
		// a shrunken row length closes the row at once
		if (col_pos < n_in)
			return;
		done_row.value = neuron_output(row_sum);
		done_row.index = row_pos[OUT_INDEX_W-1:0];
		done_row.last  = (row_pos + 1 >= n_out);
		pending_neurons.push_back(done_row);
		row_sum = '0;
		col_pos = 0;
		if (done_row.last)
			row_pos = 0;
		else
			row_pos++;
	endfunction

	// ------------------------------------------------------------------------
	// result side: stall pattern and checker
	// ------------------------------------------------------------------------

	// a new hold request starts a long stall, otherwise random bursts
	always @(posedge clk) begin
		if (hold_seen != hold_req) begin
			hold_seen <= hold_req;
			rx_wait   <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (rx_wait != 0) begin
			rx_wait   <= rx_wait - 1;
			out_ready <= 1'b0;
		end else if (rx_gaps_on && $urandom_range(0, 9) == 0) begin
			rx_wait   <= $urandom_range(0, 16);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// every result transaction is matched against the oldest owed neuron
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (pending_neurons.size() == 0) begin
				if (bad_results < MAX_SHOWN)
					$display("unexpected result: value %0d index %0d last %0b",
						out_value, out_index, last);
				bad_results++;
			end else begin
				owed = pending_neurons.pop_front();
				if (out_value !== owed.value || out_index !== owed.index || last !== owed.last) begin
					if (bad_results < MAX_SHOWN)
						$display("neuron %0d: expected value %0d last %0b, got value %0d index %0d last %0b",
							owed.index, $signed(owed.value), owed.last,
							out_value, out_index, last);
					bad_results++;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// input side helpers
	// ------------------------------------------------------------------------

	// mostly small values so sums stay in range, plus extremes and full range
	function automatic logic [VALUE_W-1:0] pick_value();
		int small_val;
		small_val = int'($urandom_range(0, 1023)) - 512;
		case ($urandom_range(0, 7))
			0: begin
				case ($urandom_range(0, 5))
					0:       return 16'h8000;
					1:       return 16'h7FFF;
					2:       return 16'h0000;
					3:       return 16'h0001;
					4:       return 16'hFFFF;
					default: return 16'h0100;
				endcase
			end
			1, 2:    return VALUE_W'($urandom);
			default: return small_val[VALUE_W-1:0];
		endcase
	endfunction

	// one input transaction, with an optional idle burst in front
	task automatic send_item(input logic kind, input logic [VALUE_W-1:0] v);
		if (tx_gaps_on && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_valid <= 1'b1;
		op       <= kind;
		value    <= v;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_layer_item(kind, v);
		items_sent++;
	endtask

	// weights until the current row closes, with stray loads if noisy
	task automatic send_row(input bit noisy);
		do begin
			if (noisy && $urandom_range(0, 15) == 0)
				send_item(OP_LOAD, pick_value());
			send_item(OP_WEIGHT, pick_value());
		end while (col_pos != 0);
	endtask

	task automatic load_row();
		repeat (row_length()) send_item(OP_LOAD, pick_value());
	endtask

	task automatic wait_results_done();
		in_valid <= 1'b0;
		while (pending_neurons.size() != 0) @(posedge clk);
	endtask

	// rows with no result may still be in flight, give the pipe time to drain
	task automatic settle();
		wait_results_done();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		apply_register(idx, data);
	endtask

	task automatic set_layer(input logic [CFG_DATA_W-1:0] relu_data, in_data, out_data);
		settle();
		write_reg(CFG_RELU_ENABLE, relu_data);
		write_reg(CFG_IN_COUNT, in_data);
		write_reg(CFG_OUT_COUNT, out_data);
		cfg_valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// registers untouched: relu on, reset row length, first neuron of a pass
	task automatic test_reset_values();
		load_row();
		send_row(1'b0);
	endtask

	// rounding at exactly half an lsb, saturation both ways, relu clamp
	task automatic test_rounding_and_saturation();
		set_layer(1'b0, 1, 3);
		send_item(OP_LOAD, 16'h0001);
		send_item(OP_WEIGHT, 16'h0080);
		send_item(OP_WEIGHT, 16'hFF80);
		send_item(OP_WEIGHT, 16'hFF7F);
		send_item(OP_WEIGHT, 16'h007F);
		send_item(OP_LOAD, 16'h7FFF);
		send_item(OP_WEIGHT, 16'h7FFF);
		send_item(OP_WEIGHT, 16'h8000);
		send_item(OP_WEIGHT, 16'h0000);
		send_item(OP_LOAD, 16'h8000);
		send_item(OP_WEIGHT, 16'h8000);
		send_item(OP_WEIGHT, 16'h0001);
		set_layer(1'b1, 1, 3);
		send_item(OP_WEIGHT, 16'h0001);
		send_item(OP_WEIGHT, 16'h8000);
	endtask

	// zero counts act as one: every weight is a full pass of one neuron
	task automatic test_count_limits();
		set_layer(1'b0, 0, 0);
		send_item(OP_LOAD, 16'hFF00);
		repeat (3) send_item(OP_WEIGHT, pick_value());
	endtask

	// load pointer wraps, then restarts when the row length shrinks under it
	task automatic test_load_wrap();
		set_layer(1'b0, 3, 2);
		repeat (5) send_item(OP_LOAD, pick_value());
		set_layer(1'b0, 2, 2);
		send_item(OP_LOAD, pick_value());
		send_row(1'b0);
		send_row(1'b0);
	endtask

	// positions survive register writes: shrink row and pass mid-stream
	task automatic test_midstream_resize();
		set_layer(1'b1, 4, 4);
		load_row();
		repeat (2) send_item(OP_WEIGHT, pick_value());
		set_layer(1'b1, 2, 4);
		send_row(1'b0);
		while (row_pos != 3) send_row(1'b0);
		set_layer(1'b1, 2, 2);
		send_row(1'b0);
		send_row(1'b0);
	endtask

	// a write to the unused index changes nothing
	task automatic test_unused_register();
		settle();
		write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
		cfg_valid <= 1'b0;
		send_row(1'b0);
		send_row(1'b0);
	endtask

	// oversized row count clamps to the full store; leaves every entry written
	task automatic test_widest_row();
		set_layer(CFG_DATA_W'($urandom_range(0, 1)), 8191, 1);
		load_row();
		send_row(1'b0);
	endtask

	// oversized neuron count clamps to the full range; index wraps after last
	task automatic test_full_pass();
		set_layer(1'b0, 1, 2047);
		send_item(OP_LOAD, pick_value());
		repeat (OUT_MAX + 1) send_row(1'b0);
	endtask

	// receiver holds off long enough that the block must stall its input
	task automatic test_output_backpressure();
		set_layer(CFG_DATA_W'($urandom_range(0, 1)), 1, 7);
		send_item(OP_LOAD, pick_value());
		hold_req <= hold_req + 1;
		repeat (80) send_row(1'b0);
	endtask

	// sender pauses until every owed neuron has come out
	task automatic test_sender_pause();
		set_layer(1'b0, 3, 5);
		load_row();
		repeat (8) send_row(1'b1);
		wait_results_done();
		repeat (8) send_row(1'b1);
	endtask

	function automatic logic [CFG_DATA_W-1:0] pick_in_count();
		case ($urandom_range(0, 8))
			6:       return '0;
			7:       return CFG_DATA_W'($urandom_range(17, 64));
			8:       return CFG_DATA_W'($urandom_range(65, 300));
			default: return CFG_DATA_W'($urandom_range(1, 16));
		endcase
	endfunction

	// upper data bits beyond the register width are dropped
	function automatic logic [CFG_DATA_W-1:0] pick_out_count();
		logic [OUT_COUNT_W-1:0] n;
		case ($urandom_range(0, 7))
			6:       n = '0;
			7:       n = OUT_COUNT_W'($urandom_range(9, 40));
			default: n = OUT_COUNT_W'($urandom_range(1, 8));
		endcase
		if ($urandom_range(0, 3) == 0)
			return {2'($urandom), n};
		return {2'b00, n};
	endfunction

	// random settings; well-formed rows, stray loads and half-finished rows
	task automatic test_random_phases(input int unsigned target);
		int unsigned stop_at;
		int          rows_cap;
		logic [CFG_DATA_W-1:0] relu_data;
		stop_at = items_sent + target;
		while (items_sent < stop_at) begin
			tx_gaps_on = ($urandom_range(0, 3) != 0);
			rx_gaps_on <= ($urandom_range(0, 3) != 0);
			relu_data = ($urandom_range(0, 1) == 0) ? CFG_DATA_W'($urandom_range(0, 1))
				: CFG_DATA_W'($urandom);
			set_layer(relu_data, pick_in_count(), pick_out_count());
			if ($urandom_range(0, 3) != 0)
				load_row();
			// long rows get only a couple of neurons
			if (row_length() > 32)
				rows_cap = 2;
			else
				rows_cap = (3 * pass_length() > 24) ? 24 : 3 * pass_length();
			repeat ($urandom_range(1, rows_cap)) send_row(1'b1);
			if (row_length() > 1 && $urandom_range(0, 4) == 0)
				repeat ($urandom_range(1, row_length() - 1))
					send_item(OP_WEIGHT, pick_value());
		end
	endtask

	// closing stretch at full rate, no idling on either side
	task automatic test_full_rate();
		tx_gaps_on = 1'b0;
		rx_gaps_on <= 1'b0;
		set_layer(CFG_DATA_W'($urandom_range(0, 1)), 4, 6);
		load_row();
		repeat (50) send_row(1'b1);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_rounding_and_saturation();
		test_count_limits();
		test_load_wrap();
		test_midstream_resize();
		test_unused_register();
		// from here on every activation entry has been written
		test_widest_row();
		test_full_pass();
		test_output_backpressure();
		test_sender_pause();
		test_random_phases(RANDOM_ITEMS);
		test_full_rate();

		settle();
		if (bad_results == 0 && pending_neurons.size() == 0) begin
			$display("fully_connected_layer_relu_top: match");
		end else begin
			$display("fully_connected_layer_relu_top: mismatch");
		end
		$finish;
	end

endmodule
